// ===== hdl/sstd_pkg.sv =====
// Package with the payload, command and status types of the slit-scan time displacement block.
`timescale 1ns / 1ps

package sstd_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_BANDS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VERTICAL_BANDS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_ORDER  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMMETRIC_FOLD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 3'd5;

  localparam logic [3:0] NUM_BANDS_RESET    = 4'd14;
  localparam logic [6:0] FRAME_WIDTH_RESET  = 7'd64;
  localparam logic [6:0] FRAME_HEIGHT_RESET = 7'd64;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic       frame_start;
  } sstd_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } sstd_out_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic div_step;
    logic calc_slot;
    logic mem_read;
    logic out_load;
  } sstd_cmd_t;

  typedef struct packed {
    logic has_result;
    logic div_done;
  } sstd_stat_t;

endpackage

// ===== hdl/sstd_ctrl.sv =====
// Controller state machine that sequences each beat through store, band division and read.
`timescale 1ns / 1ps

module sstd_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  sstd_pkg::sstd_stat_t stat,
  output sstd_pkg::sstd_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PREP = 6'b000010,
    S_DIV  = 6'b000100,
    S_SLOT = 6'b001000,
    S_READ = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = stat.has_result ? S_DIV : S_IDLE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          state_nxt = S_SLOT;
        end
      end
      S_SLOT: begin
        cmd.calc_slot = 1'b1;
        state_nxt     = S_READ;
      end
      S_READ: begin
        cmd.mem_read = 1'b1;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("controller state is not one-hot");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result loaded over a beat that was not taken");

  a_accept_to_prep: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_PREP))
    else $error("accepted beat did not enter the store step");

  a_div_to_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && stat.div_done) |=> (state_r == S_SLOT))
    else $error("finished division did not move on to slot selection");

endmodule

// ===== hdl/sstd_datapath.sv =====
// Datapath with configuration registers, raster counters, band divider and frame store.
`timescale 1ns / 1ps

module sstd_datapath #(
  parameter int MAX_BANDS  = 14,
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sstd_pkg::sstd_in_t                  in_data,
  output sstd_pkg::sstd_out_t                 out_data,
  input  logic                                cfg_wr_en,
  input  logic [sstd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sstd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  sstd_pkg::sstd_cmd_t                 cmd,
  output sstd_pkg::sstd_stat_t                stat
);

  localparam int NUM_SLOTS = MAX_BANDS + 2;
  localparam int D_W       = $clog2(NUM_SLOTS + 1);
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = $clog2(MAX_HEIGHT);
  localparam int MAX_LEN   = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int LEN_W     = $clog2(MAX_LEN + 1);
  localparam int QW        = $clog2(MAX_BANDS);
  localparam int DIV_W     = LEN_W + QW;
  localparam int CNT_W     = $clog2(QW + 1);
  localparam int ADDR_W    = SLOT_W + ROW_W + COL_W;
  localparam int MEM_DEPTH = NUM_SLOTS * (2 ** (ROW_W + COL_W));

  // Configuration registers.
  logic [3:0] num_bands_r;
  logic       vertical_r;
  logic       reverse_r;
  logic       symmetric_r;
  logic [6:0] frame_width_r;
  logic [6:0] frame_height_r;

  // Raster state.
  logic [SLOT_W-1:0] write_slot_r, write_slot_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [D_W-1:0]    frames_r, frames_nxt;

  // Current beat.
  logic [COL_W-1:0]  item_col_r, item_col_nxt;
  logic [ROW_W-1:0]  item_row_r, item_row_nxt;
  logic [23:0]       pix_r;
  logic              has_result_r, has_result_nxt;

  // Band divider and read path.
  logic [DIV_W-1:0]  rem_r, rem_nxt;
  logic [DIV_W-1:0]  dvs_r, dvs_nxt;
  logic [QW-1:0]     quot_r, quot_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SLOT_W-1:0] rd_slot_r, rd_slot_nxt;
  logic [23:0]       rd_data_r;
  logic [23:0]       out_pix_r;

  logic [23:0] mem [MEM_DEPTH];

  logic [D_W-1:0]    d_eff, ring, half, age, bd, bb;
  logic [LEN_W-1:0]  w_eff, h_eff, len_sel, pos, pos_rev, x_pos, x_inc;
  logic [SLOT_W-1:0] ws_norm;
  logic [COL_W-1:0]  col_norm;
  logic [ROW_W-1:0]  row_norm;
  logic [DIV_W-1:0]  product;
  logic [D_W:0]      slot_sum;
  logic              ge;

  always_comb begin
    if (num_bands_r < 4'd2) begin
      d_eff = D_W'(2);
    end else if (32'(num_bands_r) > MAX_BANDS) begin
      d_eff = D_W'(MAX_BANDS);
    end else begin
      d_eff = D_W'(num_bands_r);
    end
    if (frame_width_r < 7'd2) begin
      w_eff = LEN_W'(2);
    end else if (32'(frame_width_r) > MAX_WIDTH) begin
      w_eff = LEN_W'(MAX_WIDTH);
    end else begin
      w_eff = LEN_W'(frame_width_r);
    end
    if (frame_height_r < 7'd2) begin
      h_eff = LEN_W'(2);
    end else if (32'(frame_height_r) > MAX_HEIGHT) begin
      h_eff = LEN_W'(MAX_HEIGHT);
    end else begin
      h_eff = LEN_W'(frame_height_r);
    end
    ring = d_eff + D_W'(2);
    half = d_eff >> 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_bands_r    <= sstd_pkg::NUM_BANDS_RESET;
      vertical_r     <= 1'b0;
      reverse_r      <= 1'b0;
      symmetric_r    <= 1'b0;
      frame_width_r  <= sstd_pkg::FRAME_WIDTH_RESET;
      frame_height_r <= sstd_pkg::FRAME_HEIGHT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        sstd_pkg::CFG_NUM_BANDS:      num_bands_r    <= cfg_wdata[3:0];
        sstd_pkg::CFG_VERTICAL_BANDS: vertical_r     <= cfg_wdata[0];
        sstd_pkg::CFG_REVERSE_ORDER:  reverse_r      <= cfg_wdata[0];
        sstd_pkg::CFG_SYMMETRIC_FOLD: symmetric_r    <= cfg_wdata[0];
        sstd_pkg::CFG_FRAME_WIDTH:    frame_width_r  <= cfg_wdata;
        sstd_pkg::CFG_FRAME_HEIGHT:   frame_height_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Raster bookkeeping for the arriving beat.
  always_comb begin
    ws_norm  = (D_W'(write_slot_r) >= ring) ? '0 : write_slot_r;
    col_norm = (LEN_W'(col_r) >= w_eff) ? '0 : col_r;
    row_norm = (LEN_W'(row_r) >= h_eff) ? '0 : row_r;

    write_slot_nxt = ws_norm;
    frames_nxt     = frames_r;
    item_col_nxt   = col_norm;
    item_row_nxt   = row_norm;
    if (in_data.frame_start) begin
      if (frames_r != '0) begin
        write_slot_nxt = (D_W'(ws_norm) + D_W'(1) >= ring) ? '0 : ws_norm + SLOT_W'(1);
      end
      if (32'(frames_r) < NUM_SLOTS) begin
        frames_nxt = frames_r + D_W'(1);
      end
      item_col_nxt = '0;
      item_row_nxt = '0;
    end
    has_result_nxt = (frames_nxt >= ring);

    if (LEN_W'(item_col_nxt) + LEN_W'(1) >= w_eff) begin
      col_nxt = '0;
      row_nxt = (LEN_W'(item_row_nxt) + LEN_W'(1) >= h_eff) ? '0 : item_row_nxt + ROW_W'(1);
    end else begin
      col_nxt = item_col_nxt + COL_W'(1);
      row_nxt = item_row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_slot_r <= '0;
      col_r        <= '0;
      row_r        <= '0;
      frames_r     <= '0;
      has_result_r <= 1'b0;
    end else if (cmd.load) begin
      write_slot_r <= write_slot_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      frames_r     <= frames_nxt;
      has_result_r <= has_result_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_col_r <= item_col_nxt;
      item_row_r <= item_row_nxt;
      pix_r      <= {in_data.blue_in, in_data.green_in, in_data.red_in};
    end
  end

  // The band index is ((x + 1) * D - 1) / L, found by restoring division.
  always_comb begin
    len_sel = vertical_r ? w_eff : h_eff;
    pos     = vertical_r ? LEN_W'(item_col_r) : LEN_W'(item_row_r);
    pos_rev = len_sel - LEN_W'(1) - pos;
    if (symmetric_r) begin
      x_pos = (pos < pos_rev) ? pos : pos_rev;
    end else begin
      x_pos = reverse_r ? pos_rev : pos;
    end
    x_inc   = x_pos + LEN_W'(1);
    product = DIV_W'(x_inc) * DIV_W'(d_eff);
    ge      = (rem_r >= dvs_r);

    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quot_nxt = quot_r;
    cnt_nxt  = cnt_r;
    if (cmd.prep) begin
      rem_nxt  = product - DIV_W'(1);
      dvs_nxt  = DIV_W'(len_sel) << (QW - 1);
      quot_nxt = '0;
      cnt_nxt  = CNT_W'(QW - 1);
    end else if (cmd.div_step) begin
      rem_nxt  = ge ? rem_r - dvs_r : rem_r;
      dvs_nxt  = dvs_r >> 1;
      quot_nxt = QW'({quot_r, ge});
      cnt_nxt  = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
    quot_r <= quot_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Age of the band and the ring slot that holds that frame.
  always_comb begin
    bd = D_W'(quot_r);
    bb = reverse_r ? half - D_W'(1) - bd : bd;
    if (!symmetric_r) begin
      age = (bd != '0) ? d_eff - bd : d_eff;
    end else if (bd >= half) begin
      age = d_eff;
    end else begin
      age = (bb != '0) ? d_eff - half - bb : d_eff;
    end
    slot_sum = (D_W + 1)'(write_slot_r) + (D_W + 1)'(ring) - (D_W + 1)'(age);
    if (slot_sum >= (D_W + 1)'(ring)) begin
      slot_sum = slot_sum - (D_W + 1)'(ring);
    end
    rd_slot_nxt = SLOT_W'(slot_sum);
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_slot) begin
      rd_slot_r <= rd_slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      mem[ADDR_W'({write_slot_r, item_row_r, item_col_r})] <= pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_read) begin
      rd_data_r <= mem[ADDR_W'({rd_slot_r, item_row_r, item_col_r})];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_pix_r <= rd_data_r;
    end
  end

  assign out_data.red_out   = out_pix_r[7:0];
  assign out_data.green_out = out_pix_r[15:8];
  assign out_data.blue_out  = out_pix_r[23:16];

  assign stat.has_result = has_result_r;
  assign stat.div_done   = (cnt_r == '0);

endmodule

// ===== hdl/slit_scan_time_displacement_top.sv =====
// Top level of the slit-scan time displacement block.
//
//   Channel  Handshake            Payload
//   in_      in_valid / in_ready  in_data   (sstd_in_t: pixel and frame start)
//   out_     out_valid/out_ready  out_data  (sstd_out_t: displaced pixel)
//   cfg_     cfg_wr_en            cfg_index, cfg_wdata (one register per write)
//
// A beat that yields no result passes only the load and store steps; one that yields a
// result also runs the restoring divider that finds the band, then slot selection and the read.
// The result waits in an output register; a stalled out_ready holds only the final step.
// Reset is synchronous and clears configuration, counters and control state, not data registers or the frame store.
`timescale 1ns / 1ps

module slit_scan_time_displacement_top #(
  parameter int MAX_BANDS  = 14,
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  sstd_pkg::sstd_in_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output sstd_pkg::sstd_out_t             out_data,
  input  logic                            cfg_wr_en,
  input  logic [sstd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sstd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  sstd_pkg::sstd_cmd_t  cmd;
  sstd_pkg::sstd_stat_t stat;

  sstd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sstd_datapath #(
    .MAX_BANDS  (MAX_BANDS),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
